>>> sv/audio_decimate_gain_ring_buffer_core_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the decimating gain ring buffer
// shared property wrappers, clocked on clk_i and muted during reset
// ----------------------------------------------------------------------------
`ifndef AUDIO_DECIMATE_GAIN_RING_BUFFER_CORE_MACROS_SVH
`define AUDIO_DECIMATE_GAIN_RING_BUFFER_CORE_MACROS_SVH

// same-cycle implication
`define ADGRB_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ADGRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/adgrb_pkg.sv
// ----------------------------------------------------------------------------
// adgrb_pkg
// shared types and constants of the decimating gain ring buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package adgrb_pkg;

  localparam int RING_DEPTH = 576;
  localparam int MAX_RATIO  = 16;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int RATIO_W    = 5;
  localparam int ACC_W      = 20;
  localparam int GAIN_W     = 16;
  localparam int GPROD_W    = 2 * GAIN_W;
  localparam int MAG_W      = ACC_W + GPROD_W;
  localparam int FRAC_SHIFT = 24;
  localparam int DIVIDEND_W = MAG_W - FRAC_SHIFT;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
  localparam int IDX_W      = 10;
  localparam int ENTRY_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_FRAME = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATIO    = 3'd0,
    REG_CHANNELS = 3'd1,
    REG_SENS     = 3'd2,
    REG_LGAIN    = 3'd3,
    REG_RGAIN    = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAIN,
    ST_MUL,
    ST_DIV,
    ST_STORE,
    ST_READ
  } state_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [RATIO_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> sv/adgrb_if.sv
// ----------------------------------------------------------------------------
// adgrb channel interfaces
// input, result and register write channels with valid/ready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface adgrb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [9:0]         read_index;
  logic [9:0]         window_size;
  logic               window_start;
  modport source (output valid, cmd, left_sample, right_sample, read_index, window_size,
                  window_start, input ready);
  modport sink (input valid, cmd, left_sample, right_sample, read_index, window_size,
                window_start, output ready);
endinterface

interface adgrb_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         left_byte;
  logic [7:0]         right_byte;
  logic signed [15:0] left_level;
  logic signed [15:0] right_level;
  logic               silenced;
  logic               drained;
  modport source (output valid, left_byte, right_byte, left_level, right_level, silenced,
                  drained, input ready);
  modport sink (input valid, left_byte, right_byte, left_level, right_level, silenced,
                drained, output ready);
endinterface

interface adgrb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/adgrb_ring_ram.sv
// ----------------------------------------------------------------------------
// adgrb_ring_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module adgrb_ring_ram #(
  parameter int DEPTH = 576,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/adgrb_divider.sv
// ----------------------------------------------------------------------------
// adgrb_divider
// restoring divider, one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module adgrb_divider import adgrb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [RATIO_W-1:0]    rem_q, rem_d;
  logic [RATIO_W-1:0]    div_q, div_d;
  logic [RATIO_W:0]      shifted;
  logic                  ge;

  assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = shifted >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? RATIO_W'(shifted - {1'b0, div_q}) : shifted[RATIO_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> sv/audio_decimate_gain_ring_buffer_core.sv
// ----------------------------------------------------------------------------
// audio_decimate_gain_ring_buffer_core
// boxcar decimator with gain feeding a stereo ring, read one entry per beat
// ----------------------------------------------------------------------------
// a frame that does not close a group, a clear or an unused command is done on acceptance
// a frame that closes a group runs through accept, gain and sample multiply,
//   the bit-serial divider by the frame count (load, 28 bits, done),
//   then the ring write
// a read passes the registered ring read and then the result register; it waits
//   while the result register is still held by the receiver
// reset empties the ring at once; entries outside the fill count read as zero
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_decimate_gain_ring_buffer_core_macros.svh"
module audio_decimate_gain_ring_buffer_core import adgrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  adgrb_cfg_if.sink   cfg_i,
  adgrb_in_if.sink    in_i,
  adgrb_out_if.source out_o
);

  // configuration registers
  logic [RATIO_W-1:0] ratio_q;
  logic [1:0]         chans_q;
  logic [GAIN_W-1:0]  sens_q, lgain_q, rgain_q;

  // control state
  state_e             state_q, state_d;
  logic signed [ACC_W-1:0] lacc_q, lacc_d, racc_q, racc_d;
  logic [3:0]         phase_q, phase_d;
  logic [RING_AW-1:0] wp_q, wp_d;
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic [RING_AW-1:0] snap_q, snap_d;
  logic [2:0]         stale_q, stale_d;
  logic               drained_q, drained_d;
  logic               out_valid_q, out_valid_d;
  logic               dstart_q, dstart_d;

  // datapath registers
  logic signed [ACC_W-1:0] lsum_q, lsum_d, rsum_q, rsum_d;
  logic [RATIO_W-1:0] frames_q, frames_d;
  logic [GPROD_W-1:0] lg_q, rg_q;
  logic [DIVIDEND_W-1:0] lt_q, rt_q;
  logic               rd_ok_q, rd_ok_d;
  logic               rd_sil_q, rd_sil_d;

  // output register
  logic [7:0]         o_lbyte_q, o_rbyte_q;
  logic signed [15:0] o_llev_q, o_rlev_q;
  logic               o_sil_q, o_drn_q;

  // ring port
  logic               ram_we, ram_re;
  logic [RING_AW-1:0] ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  div_req_t           ldiv_req, rdiv_req;
  div_rsp_t           ldiv_rsp, rdiv_rsp;

  logic               in_acc;
  logic [RATIO_W-1:0] ratio_eff, frames_new;
  logic signed [ACC_W-1:0] lsmp, rsmp;
  logic [RING_AW+1:0] addr_sum;
  logic [RING_AW-1:0] addr_mod, idx_mod, back_dist;
  logic [IDX_W:0]     idx_ext;
  logic [2:0]         stale_new;
  logic               stale_now, silent_now;
  logic [ACC_W-1:0]   labs, rabs;
  logic [MAG_W-1:0]   lmag, rmag;
  logic signed [15:0] lclamp, rclamp;
  logic signed [15:0] rd_llev, rd_rlev;

  assign in_acc = in_i.valid && in_i.ready;

  // --------------------------------------------------------------------------
  // register writes, always accepted
  // --------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q <= RATIO_W'(1);
      chans_q <= 2'd2;
      sens_q  <= GAIN_W'(4096);
      lgain_q <= GAIN_W'(4096);
      rgain_q <= GAIN_W'(4096);
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_RATIO:    ratio_q <= cfg_i.data[RATIO_W-1:0];
        REG_CHANNELS: chans_q <= cfg_i.data[1:0];
        REG_SENS:     sens_q  <= cfg_i.data;
        REG_LGAIN:    lgain_q <= cfg_i.data;
        REG_RGAIN:    rgain_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // frame path helpers
  // --------------------------------------------------------------------------
  // ratio zero acts as one, above the maximum it saturates
  always_comb begin
    if (ratio_q == '0) begin
      ratio_eff = RATIO_W'(1);
    end else if (ratio_q > RATIO_W'(MAX_RATIO)) begin
      ratio_eff = RATIO_W'(MAX_RATIO);
    end else begin
      ratio_eff = ratio_q;
    end
  end

  assign frames_new = RATIO_W'({1'b0, phase_q}) + RATIO_W'(1);

  // mono copies left into right, zero channels sum nothing
  always_comb begin
    lsmp = '0;
    rsmp = '0;
    if (chans_q >= 2'd1) begin
      lsmp = ACC_W'(in_i.left_sample);
      rsmp = ACC_W'(in_i.left_sample);
    end
    if (chans_q >= 2'd2) begin
      rsmp = ACC_W'(in_i.right_sample);
    end
  end

  // --------------------------------------------------------------------------
  // read path helpers
  // --------------------------------------------------------------------------
  assign idx_ext = {1'b0, in_i.read_index};

  // index fits below twice the depth, one conditional subtract
  assign idx_mod = (idx_ext >= (IDX_W+1)'(RING_DEPTH)) ?
                   RING_AW'(idx_ext - (IDX_W+1)'(RING_DEPTH)) : RING_AW'(idx_ext);

  assign addr_sum = (RING_AW+2)'(wp_q) + (RING_AW+2)'(in_i.read_index);
  always_comb begin
    if (addr_sum >= (RING_AW+2)'(2 * RING_DEPTH)) begin
      addr_mod = RING_AW'(addr_sum - (RING_AW+2)'(2 * RING_DEPTH));
    end else if (addr_sum >= (RING_AW+2)'(RING_DEPTH)) begin
      addr_mod = RING_AW'(addr_sum - (RING_AW+2)'(RING_DEPTH));
    end else begin
      addr_mod = RING_AW'(addr_sum);
    end
  end

  // slot is among the last fill writes when its distance back from the
  // pointer is below the fill count, otherwise it still reads as zero
  assign back_dist = RING_AW'(RING_DEPTH - 1) - idx_mod;

  always_comb begin
    stale_new = stale_q;
    if (in_i.window_start) begin
      if (wp_q == snap_q) begin
        stale_new = (stale_q == 3'd7) ? stale_q : stale_q + 3'd1;
      end else begin
        stale_new = '0;
      end
    end
  end

  assign stale_now  = stale_new > 3'd3;
  assign silent_now = (FILL_W'(in_i.window_size) > fill_q) || stale_now;

  // --------------------------------------------------------------------------
  // scaling datapath
  // --------------------------------------------------------------------------
  assign labs = lsum_q[ACC_W-1] ? ACC_W'(-lsum_q) : ACC_W'(lsum_q);
  assign rabs = rsum_q[ACC_W-1] ? ACC_W'(-rsum_q) : ACC_W'(rsum_q);
  assign lmag = MAG_W'(labs) * MAG_W'(lg_q);
  assign rmag = MAG_W'(rabs) * MAG_W'(rg_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_GAIN) begin
      lg_q <= GPROD_W'(sens_q) * GPROD_W'(lgain_q);
      rg_q <= GPROD_W'(sens_q) * GPROD_W'(rgain_q);
    end
    if (state_q == ST_MUL) begin
      lt_q <= lmag[MAG_W-1:FRAC_SHIFT];
      rt_q <= rmag[MAG_W-1:FRAC_SHIFT];
    end
  end

  assign ldiv_req.start    = dstart_q;
  assign ldiv_req.dividend = lt_q;
  assign ldiv_req.divisor  = frames_q;
  assign rdiv_req.start    = dstart_q;
  assign rdiv_req.dividend = rt_q;
  assign rdiv_req.divisor  = frames_q;

  adgrb_divider u_ldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ldiv_req),
    .rsp_o  (ldiv_rsp)
  );

  adgrb_divider u_rdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rdiv_req),
    .rsp_o  (rdiv_rsp)
  );

  // sign back on and clamp to q1.15
  always_comb begin
    if (lsum_q[ACC_W-1]) begin
      lclamp = (ldiv_rsp.quotient >= DIVIDEND_W'(32768)) ? -16'sd32768 :
               16'(-$signed({1'b0, ldiv_rsp.quotient[15:0]}));
    end else begin
      lclamp = (ldiv_rsp.quotient > DIVIDEND_W'(32767)) ? 16'sd32767 :
               $signed(ldiv_rsp.quotient[15:0]);
    end
    if (rsum_q[ACC_W-1]) begin
      rclamp = (rdiv_rsp.quotient >= DIVIDEND_W'(32768)) ? -16'sd32768 :
               16'(-$signed({1'b0, rdiv_rsp.quotient[15:0]}));
    end else begin
      rclamp = (rdiv_rsp.quotient > DIVIDEND_W'(32767)) ? 16'sd32767 :
               $signed(rdiv_rsp.quotient[15:0]);
    end
  end

  assign ram_wdata = {rclamp, lclamp};

  // --------------------------------------------------------------------------
  // sample ring
  // --------------------------------------------------------------------------
  assign ram_we    = (state_q == ST_STORE);
  assign ram_re    = in_acc && (cmd_e'(in_i.cmd) == CMD_READ);
  assign ram_raddr = addr_mod;

  adgrb_ring_ram #(
    .DEPTH (RING_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_llev = rd_ok_q ? $signed(ram_rdata[15:0])  : 16'sd0;
  assign rd_rlev = rd_ok_q ? $signed(ram_rdata[31:16]) : 16'sd0;

  // byte is the level divided by 256 toward zero, offset by 128
  function automatic logic [7:0] to_byte(logic signed [15:0] lv);
    logic signed [16:0] biased;
    logic signed [16:0] shifted;
    biased  = lv[15] ? 17'(lv) + 17'sd255 : 17'(lv);
    shifted = biased >>> 8;
    return shifted[7:0] ^ 8'h80;
  endfunction

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    lacc_d      = lacc_q;
    racc_d      = racc_q;
    phase_d     = phase_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    snap_d      = snap_q;
    stale_d     = stale_q;
    drained_d   = drained_q;
    out_valid_d = out_valid_q;
    dstart_d    = 1'b0;
    lsum_d      = lsum_q;
    rsum_d      = rsum_q;
    frames_d    = frames_q;
    rd_ok_d     = rd_ok_q;
    rd_sil_d    = rd_sil_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (cmd_e'(in_i.cmd))
            CMD_FRAME: begin
              if (frames_new >= ratio_eff) begin
                lsum_d   = lacc_q + lsmp;
                rsum_d   = racc_q + rsmp;
                frames_d = frames_new;
                lacc_d   = '0;
                racc_d   = '0;
                phase_d  = '0;
                state_d  = ST_GAIN;
              end else begin
                lacc_d  = lacc_q + lsmp;
                racc_d  = racc_q + rsmp;
                phase_d = frames_new[3:0];
              end
            end
            CMD_CLEAR: begin
              fill_d    = '0;
              drained_d = 1'b0;
              lacc_d    = '0;
              racc_d    = '0;
              phase_d   = '0;
            end
            CMD_READ: begin
              stale_d = stale_new;
              if (in_i.window_start && (wp_q != snap_q)) begin
                snap_d = wp_q;
              end
              if (stale_now) begin
                drained_d = 1'b1;
              end
              rd_sil_d = silent_now;
              rd_ok_d  = !silent_now && (FILL_W'(back_dist) < fill_q);
              state_d  = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_GAIN: state_d = ST_MUL;
      ST_MUL: begin
        dstart_d = 1'b1;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (ldiv_rsp.done) begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        wp_d      = (wp_q == RING_AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        fill_d    = (fill_q == FILL_W'(RING_DEPTH)) ? fill_q : fill_q + 1'b1;
        drained_d = 1'b0;
        state_d   = ST_IDLE;
      end
      ST_READ: begin
        // hold the ring data until the result register frees up
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lacc_q      <= '0;
      racc_q      <= '0;
      phase_q     <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      snap_q      <= '0;
      stale_q     <= '0;
      drained_q   <= 1'b0;
      out_valid_q <= 1'b0;
      dstart_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      lacc_q      <= lacc_d;
      racc_q      <= racc_d;
      phase_q     <= phase_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      snap_q      <= snap_d;
      stale_q     <= stale_d;
      drained_q   <= drained_d;
      out_valid_q <= out_valid_d;
      dstart_q    <= dstart_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lsum_q   <= lsum_d;
    rsum_q   <= rsum_d;
    frames_q <= frames_d;
    rd_ok_q  <= rd_ok_d;
    rd_sil_q <= rd_sil_d;
    if ((state_q == ST_READ) && (!out_valid_q || out_o.ready)) begin
      o_llev_q  <= rd_llev;
      o_rlev_q  <= rd_rlev;
      o_lbyte_q <= to_byte(rd_llev);
      o_rbyte_q <= to_byte(rd_rlev);
      o_sil_q   <= rd_sil_q;
      o_drn_q   <= drained_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.left_byte   = o_lbyte_q;
  assign out_o.right_byte  = o_rbyte_q;
  assign out_o.left_level  = o_llev_q;
  assign out_o.right_level = o_rlev_q;
  assign out_o.silenced    = o_sil_q;
  assign out_o.drained     = o_drn_q;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  `ADGRB_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= FILL_W'(RING_DEPTH))
  `ADGRB_ASSERT_IMPL(a_wp_bound, 1'b1, wp_q <= RING_AW'(RING_DEPTH - 1))
  `ADGRB_ASSERT_IMPL(a_silent_zero, out_valid_q && o_sil_q,
                     (o_llev_q == 16'sd0) && (o_rlev_q == 16'sd0))
  `ADGRB_ASSERT_NEXT(a_store_advances, state_q == ST_STORE,
                     (state_q == ST_IDLE) && (fill_q != '0))

endmodule
